### hw/rtl/bkl_pkg.sv
// Shared types, command codes and reply codes for the bakery ticket lock arbiter.
// No dependencies; every other file refers to it by scoped names.
package bkl_pkg;

   // Table sizing
   localparam int MAX_SLOTS   = 16;
   localparam int TICKET_BITS = 16;
   localparam int SLOT_BITS   = $clog2(MAX_SLOTS);
   localparam int COUNT_BITS  = $clog2(MAX_SLOTS + 1);
   localparam int ID_BITS     = 32;
   localparam int LIMIT_BITS  = 5;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Command codes on the request channel
   localparam logic [1:0] CMD_REGISTER = 2'd0;
   localparam logic [1:0] CMD_LOCK     = 2'd1;
   localparam logic [1:0] CMD_UNLOCK   = 2'd2;

   // Reply kinds
   localparam logic [1:0] KIND_REGISTER = 2'd0;
   localparam logic [1:0] KIND_LOCK     = 2'd1;
   localparam logic [1:0] KIND_UNLOCK   = 2'd2;
   localparam logic [1:0] KIND_GRANT    = 2'd3;

   // Status codes (meaning depends on the reply kind)
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_FULL      = 2'd1;
   localparam logic [1:0] STS_GRANTED   = 2'd0;
   localparam logic [1:0] STS_QUEUED    = 2'd1;
   localparam logic [1:0] STS_UNKNOWN   = 2'd2;
   localparam logic [1:0] STS_OVERFLOW  = 2'd3;
   localparam logic [1:0] STS_RELEASED  = 2'd0;
   localparam logic [1:0] STS_NO_TICKET = 2'd1;

   typedef logic [TICKET_BITS-1:0] ticket_type;
   typedef logic [SLOT_BITS-1:0]   slot_type;
   typedef logic [ID_BITS-1:0]     id_type;

   localparam ticket_type TICKET_MAX = {TICKET_BITS{1'b1}};

   // Classified operation carried through the queue
   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_LOCK     = 2'd1,
      OP_UNLOCK   = 2'd2
   } op_type;

   typedef struct packed {
      op_type op;
      id_type id;
   } queue_entry_type;

   // One result transaction
   typedef struct packed {
      logic [1:0]  reply_kind;
      logic [1:0]  status;
      logic [3:0]  slot_index;
      id_type      granted_id;
      logic [15:0] ticket_value;
      logic        last;
   } rsp_type;

endpackage

### hw/rtl/bakery_ticket_lock_arbiter.sv
// Top level of the bakery ticket lock arbiter: front end, command queue and back end.
// Depends on bkl_pkg, bkl_front, bkl_queue and bkl_back.
//
// Usage:
//   Request channel (req_*): cmd 0 registers thread_id in the next free slot, 1 asks
//   for the lock, 2 releases it. Code 3 is dropped with no response.
//   Response channel (rsp_*): one reply per command; a lock or unlock that moves the
//   lock to another slot is followed by a grant notice for the new holder, and
//   rsp_last marks the final transaction of a command.
//   csr_wr_en / csr_wr_data set the thread limit (reset value 16); write only when idle.
// Sequencing:
//   A register command goes from the queue head through the decide and send states to rsp_valid.
//   Lock and unlock first walk the registered slots one slot per cycle; a grant notice
//   adds a second send state. The back end takes the next command from the queue only
//   when it is idle again, after the last transaction of the one before is sent.
// Reset: synchronous; clears the registered count, the queue and the output stage,
//   and sets the thread limit to 16.
// Stalls: rsp_stall holds the response register; the back end waits, while the front
//   end keeps accepting into a four-entry queue until it fills, then raises req_stall.
module bakery_ticket_lock_arbiter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_thread_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_reply_kind,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot_index,
   output logic [31:0] rsp_granted_id,
   output logic [15:0] rsp_ticket_value,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);

   logic                     push;
   bkl_pkg::queue_entry_type push_entry;
   logic                     queue_full;
   logic                     queue_pop;
   logic                     queue_empty;
   bkl_pkg::queue_entry_type queue_head;
   bkl_pkg::rsp_type         rsp_data;

   // Accept and classify
   bkl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_thread_id (req_thread_id),
      .push          (push),
      .push_entry    (push_entry),
      .queue_full    (queue_full)
   );

   // Decoupling queue
   bkl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .empty      (queue_empty),
      .head       (queue_head)
   );

   // Table sequencer and output register
   bkl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   assign rsp_reply_kind   = rsp_data.reply_kind;
   assign rsp_status       = rsp_data.status;
   assign rsp_slot_index   = rsp_data.slot_index;
   assign rsp_granted_id   = rsp_data.granted_id;
   assign rsp_ticket_value = rsp_data.ticket_value;
   assign rsp_last         = rsp_data.last;

endmodule

### hw/rtl/bkl_front.sv
// Front end: accepts request transactions, classifies the command and drops unused codes.
// Depends on bkl_pkg; feeds bkl_queue.
module bkl_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_cmd,
   input  logic [31:0]              req_thread_id,
   output logic                     push,
   output bkl_pkg::queue_entry_type push_entry,
   input  logic                     queue_full
);

   logic             front_valid_ff, front_valid_in;
   bkl_pkg::op_type  front_op_ff, front_op_in;
   bkl_pkg::id_type  front_id_ff;
   logic             accept;
   logic             cmd_known;

   // Hold one classified transaction; stall only when it cannot move on
   assign req_stall = front_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = front_valid_ff && !queue_full;

   // Command decode
   always_comb begin
      cmd_known   = 1'b1;
      front_op_in = bkl_pkg::OP_REGISTER;
      case (req_cmd)
         bkl_pkg::CMD_REGISTER: front_op_in = bkl_pkg::OP_REGISTER;
         bkl_pkg::CMD_LOCK:     front_op_in = bkl_pkg::OP_LOCK;
         bkl_pkg::CMD_UNLOCK:   front_op_in = bkl_pkg::OP_UNLOCK;
         default:               cmd_known   = 1'b0;
      endcase
   end

   always_comb begin
      if (accept) begin
         front_valid_in = cmd_known;
      end else if (push) begin
         front_valid_in = 1'b0;
      end else begin
         front_valid_in = front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_op_ff <= front_op_in;
         front_id_ff <= req_thread_id;
      end
   end

   assign push_entry.op = front_op_ff;
   assign push_entry.id = front_id_ff;

endmodule

### hw/rtl/bkl_queue.sv
// Short command queue that decouples the front end from the table sequencer.
// Depends on bkl_pkg.
module bkl_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bkl_pkg::queue_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output bkl_pkg::queue_entry_type head
);

   bkl_pkg::queue_entry_type        entries [bkl_pkg::QUEUE_DEPTH];
   logic [bkl_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [bkl_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [bkl_pkg::QCNT_BITS-1:0]   fill_ff, fill_in;
   logic                            do_push, do_pop;

   assign full    = (fill_ff == bkl_pkg::QCNT_BITS'(bkl_pkg::QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries[rd_ptr_ff];

   // Pointer and fill bookkeeping; pointers wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         if (wr_ptr_ff == bkl_pkg::QPTR_BITS'(bkl_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + bkl_pkg::QPTR_BITS'(1);
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == bkl_pkg::QPTR_BITS'(bkl_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + bkl_pkg::QPTR_BITS'(1);
         end
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + bkl_pkg::QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - bkl_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/bkl_back.sv
// Back end: slot table, walking sequencer for lookup / ticket maximum / holder search,
// and the response output register. Depends on bkl_pkg; fed by bkl_queue.
module bkl_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [4:0]               csr_wr_data,
   input  logic                     queue_empty,
   input  bkl_pkg::queue_entry_type queue_head,
   output logic                     queue_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bkl_pkg::rsp_type         rsp_data
);

   typedef enum logic [4:0] {
      SEQ_IDLE   = 5'b00001,
      SEQ_WALK   = 5'b00010,
      SEQ_DECIDE = 5'b00100,
      SEQ_SEND1  = 5'b01000,
      SEQ_SEND2  = 5'b10000
   } seq_state_type;

   // Slot table
   bkl_pkg::id_type     ids_mem [bkl_pkg::MAX_SLOTS];
   bkl_pkg::ticket_type tk_mem  [bkl_pkg::MAX_SLOTS];

   seq_state_type                    state_ff, state_in;
   logic [bkl_pkg::COUNT_BITS-1:0]   count_ff, count_in;
   logic [bkl_pkg::COUNT_BITS-1:0]   walk_ff, walk_in;
   logic [bkl_pkg::LIMIT_BITS-1:0]   limit_ff;
   bkl_pkg::op_type                  op_ff;
   bkl_pkg::id_type                  id_ff;

   // Walk accumulators
   logic                 found_ff, found_in;
   bkl_pkg::slot_type    slot_ff, slot_in;
   bkl_pkg::ticket_type  slot_tk_ff, slot_tk_in;
   bkl_pkg::ticket_type  top_ff, top_in;
   logic                 bef_valid_ff, bef_valid_in;
   bkl_pkg::slot_type    bef_idx_ff, bef_idx_in;
   bkl_pkg::ticket_type  bef_tk_ff, bef_tk_in;
   logic                 oth_valid_ff, oth_valid_in;
   bkl_pkg::slot_type    oth_idx_ff, oth_idx_in;
   bkl_pkg::ticket_type  oth_tk_ff, oth_tk_in;
   bkl_pkg::id_type      oth_id_ff, oth_id_in;

   // Results waiting for the output register
   bkl_pkg::rsp_type     res1_ff, res1_in, res2_ff, res2_in;
   logic                 need2_ff, need2_in;
   logic                 out_valid_ff, out_valid_in;
   bkl_pkg::rsp_type     out_ff, out_in;

   // Table write port
   logic                 tk_wr_en, id_wr_en;
   bkl_pkg::slot_type    tk_wr_idx;
   bkl_pkg::ticket_type  tk_wr_val;

   bkl_pkg::slot_type    walk_idx;
   bkl_pkg::id_type      rd_id;
   bkl_pkg::ticket_type  rd_tk;
   logic                 is_match;
   logic                 out_free;
   logic                 table_room;
   logic                 notice;
   bkl_pkg::ticket_type  new_tk;

   assign walk_idx = walk_ff[bkl_pkg::SLOT_BITS-1:0];
   assign rd_id    = ids_mem[walk_idx];
   assign rd_tk    = tk_mem[walk_idx];
   assign is_match = !found_ff && (rd_id == id_ff);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign new_tk   = top_ff + bkl_pkg::TICKET_BITS'(1);

   assign table_room = (32'(count_ff) < 32'(limit_ff)) &&
                       (32'(count_ff) < 32'(bkl_pkg::MAX_SLOTS));

   // Holder moves to another slot: the best other slot differs from the holder before
   assign notice = oth_valid_ff && !(bef_valid_ff && (bef_idx_ff == oth_idx_ff));

   assign queue_pop = (state_ff == SEQ_IDLE) && !queue_empty;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      walk_in      = walk_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      slot_tk_in   = slot_tk_ff;
      top_in       = top_ff;
      bef_valid_in = bef_valid_ff;
      bef_idx_in   = bef_idx_ff;
      bef_tk_in    = bef_tk_ff;
      oth_valid_in = oth_valid_ff;
      oth_idx_in   = oth_idx_ff;
      oth_tk_in    = oth_tk_ff;
      oth_id_in    = oth_id_ff;
      res1_in      = res1_ff;
      res2_in      = res2_ff;
      need2_in     = need2_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      tk_wr_en     = 1'b0;
      id_wr_en     = 1'b0;
      tk_wr_idx    = slot_ff;
      tk_wr_val    = '0;

      case (state_ff)
         SEQ_IDLE: begin
            walk_in      = '0;
            found_in     = 1'b0;
            slot_in      = '0;
            top_in       = '0;
            bef_valid_in = 1'b0;
            oth_valid_in = 1'b0;
            if (!queue_empty) begin
               if (queue_head.op == bkl_pkg::OP_REGISTER) begin
                  state_in = SEQ_DECIDE;
               end else begin
                  state_in = SEQ_WALK;
               end
            end
         end

         // One slot per cycle: id lookup, maximum of other tickets, holder search
         SEQ_WALK: begin
            if (walk_ff < count_ff) begin
               walk_in = walk_ff + bkl_pkg::COUNT_BITS'(1);
               if (rd_tk != '0 && (!bef_valid_ff || rd_tk < bef_tk_ff)) begin
                  bef_valid_in = 1'b1;
                  bef_idx_in   = walk_idx;
                  bef_tk_in    = rd_tk;
               end
               if (is_match) begin
                  found_in   = 1'b1;
                  slot_in    = walk_idx;
                  slot_tk_in = rd_tk;
               end else begin
                  if (rd_tk > top_ff) begin
                     top_in = rd_tk;
                  end
                  if (rd_tk != '0 && (!oth_valid_ff || rd_tk < oth_tk_ff)) begin
                     oth_valid_in = 1'b1;
                     oth_idx_in   = walk_idx;
                     oth_tk_in    = rd_tk;
                     oth_id_in    = rd_id;
                  end
               end
            end else begin
               state_in = SEQ_DECIDE;
            end
         end

         // Update the table and form the reply and optional grant notice
         SEQ_DECIDE: begin
            state_in                = SEQ_SEND1;
            need2_in                = 1'b0;
            res1_in.granted_id      = id_ff;
            res1_in.slot_index      = 4'(slot_ff);
            res1_in.ticket_value    = '0;
            res1_in.last            = 1'b1;
            res1_in.status          = bkl_pkg::STS_OK;
            res1_in.reply_kind      = bkl_pkg::KIND_REGISTER;
            res2_in.reply_kind      = bkl_pkg::KIND_GRANT;
            res2_in.status          = bkl_pkg::STS_OK;
            res2_in.slot_index      = 4'(oth_idx_ff);
            res2_in.granted_id      = oth_id_ff;
            res2_in.ticket_value    = 16'(oth_tk_ff);
            res2_in.last            = 1'b1;
            case (op_ff)
               bkl_pkg::OP_REGISTER: begin
                  if (table_room) begin
                     id_wr_en           = 1'b1;
                     tk_wr_en           = 1'b1;
                     tk_wr_idx          = count_ff[bkl_pkg::SLOT_BITS-1:0];
                     tk_wr_val          = '0;
                     count_in           = count_ff + bkl_pkg::COUNT_BITS'(1);
                     res1_in.slot_index = 4'(count_ff[bkl_pkg::SLOT_BITS-1:0]);
                  end else begin
                     res1_in.status     = bkl_pkg::STS_FULL;
                     res1_in.slot_index = '0;
                  end
               end
               bkl_pkg::OP_LOCK: begin
                  res1_in.reply_kind = bkl_pkg::KIND_LOCK;
                  if (!found_ff) begin
                     res1_in.status     = bkl_pkg::STS_UNKNOWN;
                     res1_in.slot_index = '0;
                  end else if (top_ff == bkl_pkg::TICKET_MAX) begin
                     res1_in.status       = bkl_pkg::STS_OVERFLOW;
                     res1_in.ticket_value = 16'(slot_tk_ff);
                  end else begin
                     // New ticket tops every other one: granted only if no other holds one
                     tk_wr_en             = 1'b1;
                     tk_wr_val            = new_tk;
                     res1_in.ticket_value = 16'(new_tk);
                     res1_in.status       = oth_valid_ff ? bkl_pkg::STS_QUEUED
                                                         : bkl_pkg::STS_GRANTED;
                     need2_in             = notice;
                     res1_in.last         = !notice;
                  end
               end
               bkl_pkg::OP_UNLOCK: begin
                  res1_in.reply_kind = bkl_pkg::KIND_UNLOCK;
                  if (!found_ff) begin
                     res1_in.status     = bkl_pkg::STS_UNKNOWN;
                     res1_in.slot_index = '0;
                  end else if (slot_tk_ff == '0) begin
                     res1_in.status = bkl_pkg::STS_NO_TICKET;
                  end else begin
                     tk_wr_en       = 1'b1;
                     tk_wr_val      = '0;
                     res1_in.status = bkl_pkg::STS_RELEASED;
                     need2_in       = notice;
                     res1_in.last   = !notice;
                  end
               end
               default: begin
                  state_in = SEQ_IDLE;
               end
            endcase
         end

         SEQ_SEND1: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = res1_ff;
               state_in     = need2_ff ? SEQ_SEND2 : SEQ_IDLE;
            end
         end

         SEQ_SEND2: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = res2_ff;
               state_in     = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         limit_ff     <= bkl_pkg::LIMIT_BITS'(16);
         out_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         bef_valid_ff <= 1'b0;
         oth_valid_ff <= 1'b0;
         need2_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         found_ff     <= found_in;
         bef_valid_ff <= bef_valid_in;
         oth_valid_ff <= oth_valid_in;
         need2_ff     <= need2_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      walk_ff    <= walk_in;
      slot_ff    <= slot_in;
      slot_tk_ff <= slot_tk_in;
      top_ff     <= top_in;
      bef_idx_ff <= bef_idx_in;
      bef_tk_ff  <= bef_tk_in;
      oth_idx_ff <= oth_idx_in;
      oth_tk_ff  <= oth_tk_in;
      oth_id_ff  <= oth_id_in;
      res1_ff    <= res1_in;
      res2_ff    <= res2_in;
      out_ff     <= out_in;
      if (queue_pop) begin
         op_ff <= queue_head.op;
         id_ff <= queue_head.id;
      end
   end

   // Slot table writes
   always_ff @(posedge clock) begin
      if (id_wr_en) begin
         ids_mem[count_ff[bkl_pkg::SLOT_BITS-1:0]] <= id_ff;
      end
      if (tk_wr_en) begin
         tk_mem[tk_wr_idx] <= tk_wr_val;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### hw/rtl/bkl_checker.sv
// Port-level checker for the bakery ticket lock arbiter, bound to the top level.
// Depends on bkl_pkg for reply and status codes.
module bkl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_reply_kind,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_granted_id,
   input logic [15:0] rsp_ticket_value,
   input logic        rsp_last
);

   // A stalled response stays valid and keeps its granted id and ticket value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_granted_id)
                                 && $stable(rsp_ticket_value))
      else $error("stalled response changed");

   // A grant notice always closes a command with status zero
   a_grant_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind == bkl_pkg::KIND_GRANT |->
         rsp_status == bkl_pkg::STS_OK && rsp_last)
      else $error("malformed grant notice");

   // Only a lock or unlock reply can be followed by a notice
   a_nonlast_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |->
         rsp_reply_kind == bkl_pkg::KIND_LOCK || rsp_reply_kind == bkl_pkg::KIND_UNLOCK)
      else $error("unexpected non-final response");

   // Register replies carry no ticket and stand alone
   a_register_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind == bkl_pkg::KIND_REGISTER |->
         rsp_ticket_value == '0 && rsp_last)
      else $error("malformed register reply");

endmodule

bind bakery_ticket_lock_arbiter bkl_checker u_bkl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_reply_kind   (rsp_reply_kind),
   .rsp_status       (rsp_status),
   .rsp_granted_id   (rsp_granted_id),
   .rsp_ticket_value (rsp_ticket_value),
   .rsp_last         (rsp_last)
);
